/* sv/duty_interval_statistics_core_defines.svh */
// Assertion macros shared by the statistics core.
// The macros expect clk and arst_n in the scope where they are used.
`ifndef DUTY_INTERVAL_STATISTICS_CORE_DEFINES_SVH
`define DUTY_INTERVAL_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication.
`define DIS_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DIS_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dis_pkg.sv */
package dis_pkg;

	// Item counting saturates at this many periods.
	localparam int MAX_PERIODS = 65536;
	localparam int CNT_W = $clog2(MAX_PERIODS + 1);

	// Queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	// Serial divider: one quotient bit per cycle.
	localparam int DIV_STEPS = 64;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	localparam logic [47:0] WINDOW_RESET = 48'd300000;
	localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [13:0] PCT_SCALE = 14'd10000;

	// Register map: one 64-bit register slot per index.
	localparam int PADDR_W = 4;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'b0;

	typedef struct packed {
		logic [31:0] duration_ms;
		logic        last_period;
	} item_t;

	typedef struct packed {
		logic [47:0] recorded_total;
		logic [47:0] measured_total;
		logic [47:0] active_total;
		logic [47:0] inactive_total;
		logic [13:0] active_hundredths;
		logic [31:0] longest_active;
		logic [31:0] longest_inactive;
		logic [31:0] mean_active;
		logic [47:0] mean_inactive;
		logic [31:0] first_period;
		logic        cut_found;
		logic [15:0] cut_index;
	} result_t;

	// Classified item as it travels through the queue.
	typedef struct packed {
		logic [31:0] duration;
		logic        last;
		logic        active;
		logic        first;
		logic        skip;
		logic [15:0] idx;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_SETTLE,
		ST_PREP,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_MA_GO,
		ST_MA_WAIT,
		ST_MI_GO,
		ST_MI_WAIT,
		ST_OUT
	} back_state_t;

endpackage

/* sv/duty_interval_statistics_core.sv */
// A beat is queued, popped, then accumulated by stage one and stage two. A final
// beat then starts the report: settle, prepare, the three report divisions that
// share one serial divider, and the output state.
// Throughput: one beat per cycle, except that accumulation pauses during a report.
// Reset: window returns to 300000 ms, the accumulators and the queue clear at once.
module duty_interval_statistics_core import dis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result
);

	logic [47:0]          window_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 push;
	entry_t               push_entry;
	logic                 q_full;
	logic                 pop;
	entry_t               head;
	logic                 not_empty;

	// Configuration register.
	assign pready = 1'b1;
	assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
	assign prdata = (reg_idx == REG_WINDOW) ? {16'b0, window_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_WINDOW) begin
			window_q <= pwdata[47:0];
		end
	end

	dis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	dis_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	dis_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window       (window_q),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* sv/dis_front.sv */
module dis_front import dis_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  item_t  item,
	input  logic   item_valid,
	output logic   item_ready,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	logic [CNT_W-1:0] cnt_q;
	logic             in_limit;

	// Classify the beat by its position in the recording.
	assign in_limit = cnt_q < CNT_W'(MAX_PERIODS);
	assign item_ready = !q_full;
	assign push = item_valid && !q_full;

	always_comb begin
		push_entry.duration = item.duration_ms;
		push_entry.last     = item.last_period;
		push_entry.active   = ~cnt_q[0];
		push_entry.first    = cnt_q == '0;
		push_entry.skip     = !in_limit;
		push_entry.idx      = 16'(cnt_q);
	end

	// Item counter saturates at the period limit and restarts after the last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (item.last_period) begin
				cnt_q <= '0;
			end else if (in_limit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

/* sv/dis_fifo.sv */
module dis_fifo import dis_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   not_empty
);

	entry_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;

	assign full = fill_q == FILL_W'(FIFO_DEPTH);
	assign not_empty = fill_q != '0;
	assign head = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

/* sv/dis_div.sv */
module dis_div import dis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [47:0] divisor,
	output div_stat_t   stat,
	output logic [63:0] quotient
);

	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [47:0]       rem_q;
	logic [63:0]       dq_q;
	logic [47:0]       dvs_q;
	logic [48:0]       shifted;
	logic [49:0]       diff;
	logic              ge;

	assign stat.busy = step_q != '0;
	assign stat.done = done_q;
	assign quotient = dq_q;

	// One restoring step: bring down the next dividend bit and try the subtract.
	assign shifted = {rem_q, dq_q[63]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge = !diff[49];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(DIV_STEPS);
			end else if (stat.busy) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and shifting dividend/quotient word.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (stat.busy) begin
			rem_q <= ge ? diff[47:0] : shifted[47:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

endmodule

/* sv/dis_back.sv */
`include "duty_interval_statistics_core_defines.svh"

module dis_back import dis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [47:0] window,
	input  entry_t      head,
	input  logic        not_empty,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	back_state_t state_q, state_n;

	// Accumulation state.
	logic [47:0] rt_q;
	logic        closed_q;
	logic [15:0] cnt_a_q;
	logic [15:0] cnt_i_q;
	logic [15:0] cut_pos_q;
	logic [31:0] first_q;
	logic        v_s1;
	logic        act_s1;
	logic [31:0] len_s1;
	logic [47:0] asum_q;
	logic [31:0] max_a_q;
	logic [31:0] max_i_q;

	// Report working registers.
	logic [47:0] measured_q;
	logic [61:0] prod_q;
	logic [47:0] inactive_q;
	logic [13:0] pct_q;
	logic [31:0] mean_a_q;
	logic [47:0] mean_i_q;
	result_t     out_q;
	logic        out_valid_q;

	logic [48:0] sum49;
	logic [47:0] rt_new;
	logic [47:0] room;
	logic        reach;
	logic [31:0] len;
	logic        take;
	logic        count;
	logic [48:0] asum49;
	logic        load;
	logic        div_start;
	logic [63:0] div_dividend;
	logic [47:0] div_divisor;
	div_stat_t   div_stat;
	logic [63:0] quotient;

	// Multiply by 10000 as a sum of shifts (8192 + 1024 + 512 + 256 + 16).
	function automatic logic [61:0] scale_pct(input logic [47:0] x);
		logic [61:0] w;
		w = {14'b0, x};
		return (w << 13) + (w << 10) + (w << 9) + (w << 8) + (w << 4);
	endfunction

	dis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Clip the period against the window end.
	always_comb begin
		sum49  = {1'b0, rt_q} + {17'b0, head.duration};
		rt_new = sum49[48] ? SAT48 : sum49[47:0];
		reach  = rt_new >= window;
		room   = (window > rt_q) ? (window - rt_q) : '0;
		len    = reach ? room[31:0] : head.duration;
		take   = pop && !head.skip;
		count  = take && !closed_q;
		asum49 = {1'b0, asum_q} + {17'b0, len_s1};
	end

	// Sequencer for accumulation and the end-of-recording report.
	always_comb begin
		state_n      = state_q;
		pop          = 1'b0;
		load         = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_ACC: begin
				pop = not_empty;
				if (not_empty && head.last) begin
					state_n = ST_SETTLE;
				end
			end
			ST_SETTLE: state_n = ST_PREP;
			ST_PREP:   state_n = ST_PCT_GO;
			ST_PCT_GO: begin
				div_dividend = {2'b00, prod_q};
				div_divisor  = measured_q;
				if (measured_q != '0) begin
					div_start = 1'b1;
					state_n   = ST_PCT_WAIT;
				end else begin
					state_n = ST_MA_GO;
				end
			end
			ST_PCT_WAIT: begin
				if (div_stat.done) begin
					state_n = ST_MA_GO;
				end
			end
			ST_MA_GO: begin
				div_dividend = {16'b0, asum_q};
				div_divisor  = {32'b0, cnt_a_q};
				if (cnt_a_q != '0) begin
					div_start = 1'b1;
					state_n   = ST_MA_WAIT;
				end else begin
					state_n = ST_MI_GO;
				end
			end
			ST_MA_WAIT: begin
				if (div_stat.done) begin
					state_n = ST_MI_GO;
				end
			end
			ST_MI_GO: begin
				div_dividend = {16'b0, inactive_q};
				div_divisor  = {32'b0, cnt_i_q};
				if (cnt_i_q != '0) begin
					div_start = 1'b1;
					state_n   = ST_MI_WAIT;
				end else begin
					state_n = ST_OUT;
				end
			end
			ST_MI_WAIT: begin
				if (div_stat.done) begin
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				load = !out_valid_q || result_ready;
				if (load) begin
					state_n = ST_ACC;
				end
			end
			default: state_n = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_n;
		end
	end

	// Stage one: running total, counts, window closing. Stage two: active sum and maxima.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q      <= '0;
			closed_q  <= 1'b0;
			cnt_a_q   <= '0;
			cnt_i_q   <= '0;
			cut_pos_q <= '0;
			first_q   <= '0;
			v_s1      <= 1'b0;
			act_s1    <= 1'b0;
			len_s1    <= '0;
			asum_q    <= '0;
			max_a_q   <= '0;
			max_i_q   <= '0;
		end else if (load) begin
			rt_q      <= '0;
			closed_q  <= 1'b0;
			cnt_a_q   <= '0;
			cnt_i_q   <= '0;
			cut_pos_q <= '0;
			first_q   <= '0;
			v_s1      <= 1'b0;
			asum_q    <= '0;
			max_a_q   <= '0;
			max_i_q   <= '0;
		end else begin
			v_s1   <= count;
			act_s1 <= head.active;
			len_s1 <= len;
			if (take) begin
				rt_q <= rt_new;
				if (head.first) begin
					first_q <= head.duration;
				end
			end
			if (count) begin
				if (head.active) begin
					cnt_a_q <= cnt_a_q + 16'd1;
				end else begin
					cnt_i_q <= cnt_i_q + 16'd1;
				end
				if (len != head.duration) begin
					closed_q  <= 1'b1;
					cut_pos_q <= head.idx;
				end
			end
			if (v_s1) begin
				if (act_s1) begin
					asum_q <= asum49[48] ? SAT48 : asum49[47:0];
					if (len_s1 > max_a_q) begin
						max_a_q <= len_s1;
					end
				end else if (len_s1 > max_i_q) begin
					max_i_q <= len_s1;
				end
			end
		end
	end

	// Report arithmetic.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				measured_q <= (rt_q < window) ? rt_q : window;
				prod_q     <= scale_pct(asum_q);
			end
			ST_PCT_GO: begin
				inactive_q <= (measured_q > asum_q) ? (measured_q - asum_q) : '0;
				pct_q      <= '0;
			end
			ST_PCT_WAIT: begin
				if (div_stat.done) begin
					pct_q <= (quotient > {50'b0, PCT_SCALE}) ? PCT_SCALE : quotient[13:0];
				end
			end
			ST_MA_GO: mean_a_q <= '0;
			ST_MA_WAIT: begin
				if (div_stat.done) begin
					mean_a_q <= quotient[31:0];
				end
			end
			ST_MI_GO: mean_i_q <= '0;
			ST_MI_WAIT: begin
				if (div_stat.done) begin
					mean_i_q <= quotient[47:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register lets accumulation go on while a report waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.recorded_total    <= rt_q;
			out_q.measured_total    <= measured_q;
			out_q.active_total      <= asum_q;
			out_q.inactive_total    <= inactive_q;
			out_q.active_hundredths <= pct_q;
			out_q.longest_active    <= max_a_q;
			out_q.longest_inactive  <= max_i_q;
			out_q.mean_active       <= mean_a_q;
			out_q.mean_inactive     <= mean_i_q;
			out_q.first_period      <= first_q;
			out_q.cut_found         <= closed_q;
			out_q.cut_index         <= closed_q ? cut_pos_q : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	`DIS_AST_IMP(a_pop_in_acc, pop, state_q == ST_ACC, "beat taken from queue outside accumulation")
	`DIS_AST_NXT(a_closed_holds, closed_q && state_q != ST_OUT, closed_q, "window reopened before report")
	`DIS_AST_IMP(a_div_free, div_start, !div_stat.busy && !div_stat.done, "divider started while in use")
	`DIS_AST_IMP(a_pct_bound, state_q == ST_OUT, pct_q <= PCT_SCALE && (measured_q != '0 || pct_q == '0), "active share out of range")

endmodule
